// ----- rtl/snapshot_schedule_from_timestamp_top_assert.svh -----
// ----------------------------------------------------------------------------
// Snapshot schedule assertion macros
// Shared property macros for the snapshot schedule block.
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_SCHEDULE_FROM_TIMESTAMP_TOP_ASSERT_SVH
`define SNAPSHOT_SCHEDULE_FROM_TIMESTAMP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSS_ASSERT_IMPL(label, ante, cons)
`define SSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// Snapshot schedule package
// Register widths, reset values and register indexes.
// ----------------------------------------------------------------------------
package sss_pkg;
  localparam int PQ_W   = 48;
  localparam int CNT_W  = 16;
  localparam int TAPS_W = 21;
  localparam int OFF_W  = 36;
  localparam int CFG_W  = 64;

  localparam logic [PQ_W-1:0]   PQ_RESET   = 48'd80530636800;
  localparam logic [CNT_W-1:0]  CNT_RESET  = 16'd1;
  localparam logic [TAPS_W-1:0] TAPS_RESET = 21'd1;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_COUNT  = 2'd1,
    REG_TAPS   = 2'd2
  } reg_index_t;
endpackage

// ----- rtl/snapshot_schedule_from_timestamp_top.sv -----
// ----------------------------------------------------------------------------
// Snapshot schedule from timestamp
// Maps a sample timestamp to the snapshot in force, its tap offset and the
// first timestamp of the next snapshot step.
// ----------------------------------------------------------------------------
// The block takes one timestamp transaction per cycle while not stalled and
// returns one result per timestamp, in order, through the chain of division
// cells, one cell per numerator bit, followed by the result register.
// Configuration must be written while idle.
module snapshot_schedule_from_timestamp_top import sss_pkg::*; #(
  parameter int FRAC_BITS      = 16,
  parameter int TIMESTAMP_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       timestamp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  snapshot_index,
  output logic [OFF_W-1:0]  tap_offset,
  output logic [63:0]       next_switch,
  output logic              switch_saturated
);
`include "snapshot_schedule_from_timestamp_top_assert.svh"

  localparam int NUM_W = TIMESTAMP_BITS + FRAC_BITS;

  logic [PQ_W-1:0]   period;
  logic [CNT_W-1:0]  count;
  logic [TAPS_W-1:0] taps;
  logic              advance;

  logic             valid_w [0:NUM_W];
  logic [NUM_W-1:0] num_w   [0:NUM_W];
  logic [PQ_W-1:0]  rem_w   [0:NUM_W];
  logic [CNT_W-1:0] idx_w   [0:NUM_W];

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PQ_RESET;
      count  <= CNT_RESET;
      taps   <= TAPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERIOD: period <= cfg_data[PQ_W-1:0];
        REG_COUNT:  count  <= cfg_data[CNT_W-1:0];
        REG_TAPS:   taps   <= cfg_data[TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign valid_w[0] = in_valid;
  assign num_w[0]   = NUM_W'(timestamp[TIMESTAMP_BITS-1:0]) << FRAC_BITS;
  assign rem_w[0]   = '0;
  assign idx_w[0]   = '0;

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    sss_cell #(
      .NUM_W (NUM_W),
      .BIT   (NUM_W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .period   (period),
      .count    (count),
      .valid_in (valid_w[k]),
      .num_in   (num_w[k]),
      .rem_in   (rem_w[k]),
      .idx_in   (idx_w[k]),
      .valid    (valid_w[k+1]),
      .num      (num_w[k+1]),
      .rem      (rem_w[k+1]),
      .idx      (idx_w[k+1])
    );
  end

  sss_final #(
    .NUM_W  (NUM_W),
    .FRAC_W (FRAC_BITS),
    .TS_W   (TIMESTAMP_BITS)
  ) u_final (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .period           (period),
    .taps             (taps),
    .valid_in         (valid_w[NUM_W]),
    .num_in           (num_w[NUM_W]),
    .rem_in           (rem_w[NUM_W]),
    .idx_in           (idx_w[NUM_W]),
    .valid            (out_valid),
    .snapshot_index   (snapshot_index),
    .tap_offset       (tap_offset),
    .next_switch      (next_switch),
    .switch_saturated (switch_saturated)
  );

  `SSS_ASSERT_NEXT(a_last_to_out, advance && valid_w[NUM_W], out_valid)
  `SSS_ASSERT_IMPL(a_sat_clamps, out_valid && switch_saturated, next_switch == 64'({TIMESTAMP_BITS{1'b1}}))
  `SSS_ASSERT_IMPL(a_idx_range, out_valid && count != '0, snapshot_index < count)
endmodule

// ----- rtl/sss_cell.sv -----
// ----------------------------------------------------------------------------
// Snapshot schedule division cell
// One restoring division step on one numerator bit, with the quotient
// folded modulo the snapshot count.
// ----------------------------------------------------------------------------
module sss_cell import sss_pkg::*; #(
  parameter int NUM_W = 80,
  parameter int BIT   = 79
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [PQ_W-1:0]  period,
  input  logic [CNT_W-1:0] count,
  input  logic             valid_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [PQ_W-1:0]  rem_in,
  input  logic [CNT_W-1:0] idx_in,
  output logic             valid,
  output logic [NUM_W-1:0] num,
  output logic [PQ_W-1:0]  rem,
  output logic [CNT_W-1:0] idx
);
  logic [PQ_W:0]    shifted;
  logic             qbit;
  logic [CNT_W:0]   doubled;
  logic [PQ_W-1:0]  rem_next;
  logic [CNT_W-1:0] idx_next;

  always_comb begin
    shifted  = {rem_in, num_in[BIT]};
    qbit     = (shifted >= {1'b0, period});
    rem_next = qbit ? PQ_W'(shifted - {1'b0, period}) : shifted[PQ_W-1:0];
    doubled  = {idx_in, qbit};
    if (count == '0) begin
      idx_next = '0;
    end else if (doubled >= {1'b0, count}) begin
      idx_next = CNT_W'(doubled - {1'b0, count});
    end else begin
      idx_next = doubled[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      num <= num_in;
      rem <= rem_next;
      idx <= idx_next;
    end
  end
endmodule

// ----- rtl/sss_final.sv -----
// ----------------------------------------------------------------------------
// Snapshot schedule result stage
// Forms the next switch time and tap offset and holds the result register.
// ----------------------------------------------------------------------------
module sss_final import sss_pkg::*; #(
  parameter int NUM_W   = 80,
  parameter int FRAC_W  = 16,
  parameter int TS_W    = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [PQ_W-1:0]   period,
  input  logic [TAPS_W-1:0] taps,
  input  logic              valid_in,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [PQ_W-1:0]   rem_in,
  input  logic [CNT_W-1:0]  idx_in,
  output logic              valid,
  output logic [CNT_W-1:0]  snapshot_index,
  output logic [OFF_W-1:0]  tap_offset,
  output logic [63:0]       next_switch,
  output logic              switch_saturated
);
  localparam int SUM_W = ((NUM_W > PQ_W) ? NUM_W : PQ_W) + 2;
  localparam int RES_W = SUM_W - FRAC_W;

  logic [SUM_W-1:0]        sum;
  logic [RES_W-1:0]        res;
  logic                    sat;
  logic [CNT_W+TAPS_W-1:0] prod;

  always_comb begin
    sum  = SUM_W'(num_in) - SUM_W'(rem_in) + SUM_W'(period)
           + SUM_W'((SUM_W'(1) << FRAC_W) - SUM_W'(1));
    res  = sum[SUM_W-1:FRAC_W];
    sat  = |res[RES_W-1:TS_W];
    prod = idx_in * taps;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (period == '0) begin
        snapshot_index   <= '0;
        tap_offset       <= '0;
        next_switch      <= 64'({TS_W{1'b1}});
        switch_saturated <= 1'b1;
      end else begin
        snapshot_index   <= idx_in;
        tap_offset       <= prod[OFF_W-1:0];
        next_switch      <= sat ? 64'({TS_W{1'b1}}) : 64'(res[TS_W-1:0]);
        switch_saturated <= sat;
      end
    end
  end
endmodule
